[rtl/tpr_pkg.sv]
`default_nettype none

package tpr_pkg;

    // default values for the top level parameters
    localparam int unsigned TICKS_PER_SECOND_DEF = 1000;
    localparam int unsigned MIN_SAMPLES_DEF      = 10;
    localparam int unsigned LOWER_HDR_BYTES_DEF  = 34;

    // shared divider geometry
    localparam int unsigned DIV_NUM_W = 80;
    localparam int unsigned DIV_DEN_W = 32;
    localparam int unsigned DIV_STEPS = 2;

    // shared multiplier geometry
    localparam int unsigned MUL_A_W   = 64;
    localparam int unsigned MUL_B_W   = 32;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_STEPS = 2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LEN = 1'b1;

    typedef struct packed {
        logic [15:0] payload_bytes;
        logic [7:0]  hdr_bytes;
        logic [31:0] now_tick;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        wait_ticks;
        logic signed [31:0] rate_gap;
        logic [31:0]        overall_bps;
        logic [31:0]        window_bps;
    } t_out_item;

    typedef struct packed {
        logic                        go;
        logic signed [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W:0]   quo;
        logic signed [DIV_DEN_W:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic               go;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic               neg;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W:0]   prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

[rtl/tpr_div.sv]
`default_nettype none

module tpr_div
    import tpr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int unsigned ITER  = DIV_NUM_W / DIV_STEPS;
    localparam int unsigned CNT_W = $clog2(ITER + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] n_num;
    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_DEN_W:0]   n_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_neg;
    logic [DIV_NUM_W-1:0] w_mag;

    // magnitude of the signed dividend
    assign w_mag = i_req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-i_req.num) : DIV_NUM_W'(i_req.num);

    // restoring steps, DIV_STEPS quotient bits per cycle while busy
    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        for (int s = 0; s < int'(DIV_STEPS); s++) begin
            n_rem = {n_rem[DIV_DEN_W-1:0], n_num[DIV_NUM_W-1]};
            n_num = {n_num[DIV_NUM_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem    = n_rem - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_num <= w_mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.num[DIV_NUM_W-1];
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    // truncation toward zero: both results take the dividend sign
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    assign o_rsp.rem  = r_neg ? -$signed({1'b0, r_rem[DIV_DEN_W-1:0]})
                              : $signed({1'b0, r_rem[DIV_DEN_W-1:0]});

endmodule

`default_nettype wire

[rtl/tpr_mul.sv]
`default_nettype none

module tpr_mul
    import tpr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    localparam int unsigned ITER  = MUL_B_W / MUL_STEPS;
    localparam int unsigned CNT_W = $clog2(ITER + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_B_W-1:0] n_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] n_acc;
    logic               r_neg;

    // shift-add over the multiplier bits, msb first
    always_comb begin
        n_acc = r_acc;
        n_b   = r_b;
        for (int s = 0; s < int'(MUL_STEPS); s++) begin
            n_acc = {n_acc[MUL_P_W-2:0], 1'b0}
                  + (n_b[MUL_B_W-1] ? {{MUL_B_W{1'b0}}, r_a} : '0);
            n_b   = {n_b[MUL_B_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_b   <= n_b;
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

endmodule

`default_nettype wire

[rtl/transmit_rate_pacer.sv]
// one item in work at a time; the sequencer runs ideal spacing, gap, budget refill and
// both rate updates only as needed, and the next item is accepted once it is back in idle
// each division runs 40 two-bit steps in the shared divider and each product 16 two-bit
// steps in the shared multiplier, both holding the sequencer while they run
// reset (i_rst_n low, synchronous) clears all counters and rates, marks the
// byte budget valid at zero, and sets both configuration registers to zero
`default_nettype none

module transmit_rate_pacer
    import tpr_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
    parameter int unsigned MIN_SAMPLES      = MIN_SAMPLES_DEF,
    parameter int unsigned LOWER_HDR_BYTES  = LOWER_HDR_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    typedef enum logic [18:0] {
        S_IDLE      = 19'(1 << 0),
        S_DECIDE    = 19'(1 << 1),
        S_IDEAL_MUL = 19'(1 << 2),
        S_IDEAL_DIV = 19'(1 << 3),
        S_GAP       = 19'(1 << 4),
        S_GAP_DIV1  = 19'(1 << 5),
        S_GAP_DIV2  = 19'(1 << 6),
        S_GAP_END   = 19'(1 << 7),
        S_FR_DIV1   = 19'(1 << 8),
        S_FR_MUL1   = 19'(1 << 9),
        S_FR_MUL2   = 19'(1 << 10),
        S_FR_DIV2   = 19'(1 << 11),
        S_RF_DIV    = 19'(1 << 12),
        S_BOOK      = 19'(1 << 13),
        S_TOT_MUL   = 19'(1 << 14),
        S_TOT_DIV   = 19'(1 << 15),
        S_SMP_MUL   = 19'(1 << 16),
        S_SMP_DIV   = 19'(1 << 17),
        S_OUT       = 19'(1 << 18)
    } t_state;

    localparam logic signed [63:0] GAP_HIGH = 64'sd110;
    localparam logic signed [63:0] GAP_LOW  = -64'sd90;
    localparam logic [31:0]        PCT      = 32'd100;

    // control and persistent state
    t_state             r_state, n_state;
    logic [31:0]        r_max_rate, n_max_rate;
    logic [15:0]        r_sample_len, n_sample_len;
    logic [31:0]        r_pkts, n_pkts;
    logic [63:0]        r_wb, n_wb;
    logic [31:0]        r_last, n_last;
    logic [31:0]        r_first, n_first;
    logic [31:0]        r_wtm, n_wtm;
    logic [63:0]        r_wbm, n_wbm;
    logic signed [31:0] r_budget, n_budget;
    logic               r_bvalid, n_bvalid;
    logic [31:0]        r_tot, n_tot;
    logic [31:0]        r_smp, n_smp;
    logic signed [31:0] r_acc, n_acc;
    logic               r_out_valid, n_out_valid;
    t_div_req           r_div_req, n_div_req;
    t_mul_req           r_mul_req, n_mul_req;

    // per item working registers
    t_in_item           r_in, n_in;
    logic [16:0]        r_wire, n_wire;
    logic [31:0]        r_wait, n_wait;
    logic signed [31:0] r_gap, n_gap;
    logic signed [63:0] r_dly, n_dly;
    logic signed [63:0] r_g, n_g;
    logic signed [63:0] r_coef, n_coef;
    logic signed [7:0]  r_frr, n_frr;
    logic signed [63:0] r_p1, n_p1;
    logic [31:0]        r_span, n_span;
    logic               r_refill, n_refill;
    logic               r_do_smp, n_do_smp;
    t_out_item          r_out, n_out;

    t_div_rsp           w_div_rsp;
    t_mul_rsp           w_mul_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [31:0] sat_rate(input logic signed [DIV_NUM_W:0] q);
        if (q[DIV_NUM_W:32] != '0) begin
            return 32'hFFFF_FFFF;
        end else begin
            return q[31:0];
        end
    endfunction

    function automatic logic signed [63:0] times100(input logic signed [63:0] v);
        return (v <<< 6) + (v <<< 5) + (v <<< 2);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [DIV_NUM_W-1:0] sext80(input logic signed [63:0] v);
        return {{(DIV_NUM_W-64){v[63]}}, v};
    endfunction

    // shared arithmetic units
    tpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    tpr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // sequencer
    always_comb begin
        logic [18:0]        tq;
        logic               ge_tq;
        logic [33:0]        ideal;
        logic [31:0]        elapsed;
        logic signed [63:0] dly;
        logic signed [63:0] c;
        logic signed [63:0] f;
        logic signed [63:0] d;
        logic signed [63:0] tmp;
        logic signed [31:0] cur;
        logic signed [31:0] g32;
        logic [31:0]        rate;
        logic signed [33:0] diff;
        logic signed [32:0] bsub;
        logic [63:0]        qabs;
        logic [7:0]         rabs;
        logic [31:0]        t;
        logic [31:0]        pk;
        logic [31:0]        span;
        logic [31:0]        first_n;
        logic [31:0]        wtm0;
        logic [31:0]        wtm1;
        logic [63:0]        wb_new;
        logic [63:0]        wbm0;
        logic [63:0]        wbm1;
        logic               do_tot;
        logic               do_smp;

        n_state      = r_state;
        n_max_rate   = r_max_rate;
        n_sample_len = r_sample_len;
        n_pkts       = r_pkts;
        n_wb         = r_wb;
        n_last       = r_last;
        n_first      = r_first;
        n_wtm        = r_wtm;
        n_wbm        = r_wbm;
        n_budget     = r_budget;
        n_bvalid     = r_bvalid;
        n_tot        = r_tot;
        n_smp        = r_smp;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid;
        n_div_req    = r_div_req;
        n_div_req.go = 1'b0;
        n_mul_req    = r_mul_req;
        n_mul_req.go = 1'b0;
        n_in         = r_in;
        n_wire       = r_wire;
        n_wait       = r_wait;
        n_gap        = r_gap;
        n_dly        = r_dly;
        n_g          = r_g;
        n_coef       = r_coef;
        n_frr        = r_frr;
        n_p1         = r_p1;
        n_span       = r_span;
        n_refill     = r_refill;
        n_do_smp     = r_do_smp;
        n_out        = r_out;

        tq      = ({2'b0, r_wire} + {1'b0, r_wire, 1'b0}) >> 2;
        ge_tq   = $signed({{2{r_budget[31]}}, r_budget}) >= $signed({15'b0, tq});
        ideal   = w_div_rsp.quo[33:0];
        elapsed = r_in.now_tick - r_last;
        dly     = $signed({30'b0, ideal}) - $signed({32'b0, elapsed});
        c       = r_coef + {{32{r_acc[31]}}, r_acc};
        f       = r_p1 + $signed(w_div_rsp.quo[63:0]);
        d       = r_dly + f;
        tmp     = $signed(w_div_rsp.quo[63:0]);
        qabs    = abs64(tmp);
        rabs    = r_frr[7] ? 8'(-r_frr) : 8'(r_frr);
        cur     = r_bvalid ? r_budget : 32'sd0;
        g32     = sat32(r_coef);
        rate    = (r_smp <= (r_tot >> 1)) ? r_tot : r_smp;
        diff    = $signed({2'b0, rate}) - $signed({2'b0, r_max_rate});
        bsub    = $signed({r_budget[31], r_budget}) - $signed({16'b0, r_wire});

        // booking arithmetic
        t       = r_in.now_tick + r_wait;
        pk      = (r_pkts == 32'hFFFF_FFFF) ? r_pkts : r_pkts + 32'd1;
        wb_new  = r_wb + {47'b0, r_wire};
        first_n = (r_first == '0) ? t : r_first;
        wtm0    = (r_first == '0) ? t : r_wtm;
        wbm0    = (r_first == '0) ? wb_new : r_wbm;
        span    = t - first_n;
        do_tot  = (first_n != '0) && (span != '0);
        wtm1    = wtm0;
        wbm1    = wbm0;
        do_smp  = 1'b0;
        if (pk >= {16'b0, r_sample_len}) begin
            wtm1   = t - wtm0;
            wbm1   = wb_new - wbm0;
            do_smp = (wtm1 != '0) && (wbm1 != '0);
        end

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_RATE:   n_max_rate   = i_cfg_data;
                REG_SAMPLE_LEN: n_sample_len = i_cfg_data[15:0];
                default:        n_max_rate   = r_max_rate;
            endcase
        end

        // result register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_wire  = 17'(i_in.payload_bytes) + 17'(i_in.hdr_bytes)
                            + 17'(LOWER_HDR_BYTES);
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_wait = '0;
                n_gap  = '0;
                if (r_max_rate == '0) begin
                    n_state = S_BOOK;
                end else if (r_bvalid && ge_tq) begin
                    n_state = S_BOOK;
                end else if (r_bvalid) begin
                    n_wait   = 32'd1;
                    n_refill = 1'b1;
                    n_state  = S_GAP;
                end else begin
                    n_mul_req.go  = 1'b1;
                    n_mul_req.a   = {47'b0, r_wire};
                    n_mul_req.b   = 32'(TICKS_PER_SECOND);
                    n_mul_req.neg = 1'b0;
                    n_state       = S_IDEAL_MUL;
                end
            end
            S_IDEAL_MUL: begin
                if (w_mul_rsp.done) begin
                    n_div_req.go  = 1'b1;
                    n_div_req.num = $signed(w_mul_rsp.prod[DIV_NUM_W-1:0]
                                  + {49'b0, r_max_rate[31:1]});
                    n_div_req.den = r_max_rate;
                    n_state       = S_IDEAL_DIV;
                end
            end
            S_IDEAL_DIV: begin
                if (w_div_rsp.done) begin
                    n_dly = dly;
                    if (dly > 64'sd0) begin
                        n_refill = 1'b0;
                        n_state  = S_GAP;
                    end else if (ideal == '0) begin
                        n_refill = 1'b1;
                        n_state  = S_GAP;
                    end else begin
                        n_bvalid = 1'b0;
                        n_state  = S_BOOK;
                    end
                end
            end
            // percent gap between measured and target rate
            S_GAP: begin
                if (r_pkts < 32'(MIN_SAMPLES)) begin
                    n_coef  = '0;
                    n_state = S_GAP_END;
                end else begin
                    n_div_req.go  = 1'b1;
                    n_div_req.num = {{(DIV_NUM_W-34){diff[33]}}, diff};
                    n_div_req.den = r_max_rate;
                    n_state       = S_GAP_DIV1;
                end
            end
            S_GAP_DIV1: begin
                if (w_div_rsp.done) begin
                    n_coef        = times100(tmp);
                    n_div_req.go  = 1'b1;
                    n_div_req.num = sext80(times100({{31{w_div_rsp.rem[32]}},
                                                     w_div_rsp.rem}));
                    n_div_req.den = r_max_rate;
                    n_state       = S_GAP_DIV2;
                end
            end
            S_GAP_DIV2: begin
                if (w_div_rsp.done) begin
                    n_coef  = r_coef + tmp;
                    n_state = S_GAP_END;
                end
            end
            S_GAP_END: begin
                n_div_req.go  = 1'b1;
                n_div_req.den = PCT;
                if (r_refill) begin
                    n_g           = {{32{g32[31]}}, g32};
                    n_div_req.num = sext80({{32{cur[31]}}, cur});
                end else begin
                    if (c > GAP_HIGH || c < GAP_LOW) begin
                        n_acc = '0;
                    end else begin
                        n_acc = sat32(c + {{32{r_acc[31]}}, r_acc});
                    end
                    n_gap         = sat32(c);
                    n_g           = c;
                    n_div_req.num = sext80(r_dly);
                end
                n_state = S_FR_DIV1;
            end
            // percent scaling: q*g + (r*g)/100
            S_FR_DIV1: begin
                if (w_div_rsp.done) begin
                    n_frr         = w_div_rsp.rem[7:0];
                    n_mul_req.go  = 1'b1;
                    n_mul_req.a   = abs64(r_g);
                    n_mul_req.b   = qabs[31:0];
                    n_mul_req.neg = r_g[63] ^ w_div_rsp.quo[DIV_NUM_W];
                    n_state       = S_FR_MUL1;
                end
            end
            S_FR_MUL1: begin
                if (w_mul_rsp.done) begin
                    n_p1          = w_mul_rsp.prod[63:0];
                    n_mul_req.go  = 1'b1;
                    n_mul_req.a   = abs64(r_g);
                    n_mul_req.b   = {24'b0, rabs};
                    n_mul_req.neg = r_g[63] ^ r_frr[7];
                    n_state       = S_FR_MUL2;
                end
            end
            S_FR_MUL2: begin
                if (w_mul_rsp.done) begin
                    n_div_req.go  = 1'b1;
                    n_div_req.num = $signed(w_mul_rsp.prod[DIV_NUM_W-1:0]);
                    n_div_req.den = PCT;
                    n_state       = S_FR_DIV2;
                end
            end
            S_FR_DIV2: begin
                if (w_div_rsp.done) begin
                    if (r_refill) begin
                        n_p1          = f;
                        n_div_req.go  = 1'b1;
                        n_div_req.num = {48'b0, r_max_rate};
                        n_div_req.den = 32'(TICKS_PER_SECOND);
                        n_state       = S_RF_DIV;
                    end else begin
                        if (d > 64'sd0) begin
                            n_wait = (d > 64'sh0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
                        end else begin
                            n_wait = '0;
                        end
                        n_bvalid = 1'b0;
                        n_state  = S_BOOK;
                    end
                end
            end
            // budget refill
            S_RF_DIV: begin
                if (w_div_rsp.done) begin
                    n_budget = sat32(tmp - r_p1);
                    n_bvalid = 1'b1;
                    n_state  = S_BOOK;
                end
            end
            // book the item as sent
            S_BOOK: begin
                n_pkts   = pk;
                n_wb     = wb_new;
                n_last   = t;
                n_first  = first_n;
                n_wtm    = wtm1;
                n_wbm    = wbm1;
                n_span   = span;
                n_do_smp = do_smp;
                if (r_bvalid) begin
                    n_budget = sat32({{31{bsub[32]}}, bsub});
                end
                if (do_tot) begin
                    n_mul_req.go  = 1'b1;
                    n_mul_req.a   = wb_new;
                    n_mul_req.b   = 32'(TICKS_PER_SECOND);
                    n_mul_req.neg = 1'b0;
                    n_state       = S_TOT_MUL;
                end else if (do_smp) begin
                    n_mul_req.go  = 1'b1;
                    n_mul_req.a   = wbm1;
                    n_mul_req.b   = 32'(TICKS_PER_SECOND);
                    n_mul_req.neg = 1'b0;
                    n_state       = S_SMP_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TOT_MUL: begin
                if (w_mul_rsp.done) begin
                    n_div_req.go  = 1'b1;
                    n_div_req.num = $signed(w_mul_rsp.prod[DIV_NUM_W-1:0]);
                    n_div_req.den = r_span;
                    n_state       = S_TOT_DIV;
                end
            end
            S_TOT_DIV: begin
                if (w_div_rsp.done) begin
                    n_tot = sat_rate(w_div_rsp.quo);
                    if (r_do_smp) begin
                        n_mul_req.go  = 1'b1;
                        n_mul_req.a   = r_wbm;
                        n_mul_req.b   = 32'(TICKS_PER_SECOND);
                        n_mul_req.neg = 1'b0;
                        n_state       = S_SMP_MUL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SMP_MUL: begin
                if (w_mul_rsp.done) begin
                    n_div_req.go  = 1'b1;
                    n_div_req.num = $signed(w_mul_rsp.prod[DIV_NUM_W-1:0]);
                    n_div_req.den = r_wtm;
                    n_state       = S_SMP_DIV;
                end
            end
            S_SMP_DIV: begin
                if (w_div_rsp.done) begin
                    n_smp   = sat_rate(w_div_rsp.quo);
                    n_state = S_OUT;
                end
            end
            // hand the result to the output register
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.wait_ticks  = r_wait;
                    n_out.rate_gap    = r_gap;
                    n_out.overall_bps = r_tot;
                    n_out.window_bps  = r_smp;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_rate   <= '0;
            r_sample_len <= '0;
            r_pkts       <= '0;
            r_wb         <= '0;
            r_last       <= '0;
            r_first      <= '0;
            r_wtm        <= '0;
            r_wbm        <= '0;
            r_budget     <= '0;
            r_bvalid     <= 1'b1;
            r_tot        <= '0;
            r_smp        <= '0;
            r_acc        <= '0;
            r_out_valid  <= 1'b0;
            r_div_req    <= '0;
            r_mul_req    <= '0;
        end else begin
            r_state      <= n_state;
            r_max_rate   <= n_max_rate;
            r_sample_len <= n_sample_len;
            r_pkts       <= n_pkts;
            r_wb         <= n_wb;
            r_last       <= n_last;
            r_first      <= n_first;
            r_wtm        <= n_wtm;
            r_wbm        <= n_wbm;
            r_budget     <= n_budget;
            r_bvalid     <= n_bvalid;
            r_tot        <= n_tot;
            r_smp        <= n_smp;
            r_acc        <= n_acc;
            r_out_valid  <= n_out_valid;
            r_div_req    <= n_div_req;
            r_mul_req    <= n_mul_req;
        end
    end

    // per item working registers
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_wire   <= n_wire;
        r_wait   <= n_wait;
        r_gap    <= n_gap;
        r_dly    <= n_dly;
        r_g      <= n_g;
        r_coef   <= n_coef;
        r_frr    <= n_frr;
        r_p1     <= n_p1;
        r_span   <= n_span;
        r_refill <= n_refill;
        r_do_smp <= n_do_smp;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECIDE))
        else $error("accepted item did not start the sequencer");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_IDEAL_DIV || r_state == S_GAP_DIV1 ||
                            r_state == S_GAP_DIV2 || r_state == S_FR_DIV1 ||
                            r_state == S_FR_DIV2 || r_state == S_RF_DIV ||
                            r_state == S_TOT_DIV || r_state == S_SMP_DIV))
        else $error("divider finished outside a waiting state");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result register overwritten while stalled");

    a_unlimited_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_max_rate == '0) |=> (r_state == S_BOOK && r_wait == '0))
        else $error("unlimited rate did not send at once");
`endif

endmodule

`default_nettype wire

[tb/transmit_rate_pacer_tb.sv]
`timescale 1ns / 1ps

module transmit_rate_pacer_tb;
    import tpr_pkg::*;

    localparam int unsigned TPS      = TICKS_PER_SECOND_DEF;
    localparam int unsigned MIN_PKTS = MIN_SAMPLES_DEF;
    localparam int unsigned LOW_HDR  = LOWER_HDR_BYTES_DEF;
    localparam int          SETTLE   = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;

    transmit_rate_pacer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_in_item  packet_queue[$];
    t_out_item pacing_expected[$];
    int        errors;
    int        packets_offered;
    int        results_checked;
    int        waited_results;
    int        gapped_results;
    logic      in_fire;
    logic      out_fire;
    int        send_gap;
    int        recv_stall;
    logic      gap_burst;
    logic      stall_burst;

    // pacer state mirror
    logic [31:0] cfg_rate;
    logic [15:0] cfg_window;
    logic [31:0] pkt_count;
    logic [63:0] wire_total;
    logic [31:0] last_tick;
    logic [31:0] first_tick;
    logic [31:0] win_tick;
    logic [63:0] win_bytes;
    longint      budget;
    logic        budget_ok;
    logic [31:0] rate_total;
    logic [31:0] rate_window;
    longint      gap_accum;

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(bytes*TPS/span) saturated to 32 bits
    function automatic logic [31:0] bytes_per_sec(logic [63:0] bytes, logic [31:0] span);
        logic [127:0] q;
        q = ({64'h0, bytes} * 128'(TPS)) / {96'h0, span};
        return (q > 128'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    endfunction

    function automatic longint percent_of(longint x, longint n);
        return (x / 100) * n + ((x % 100) * n) / 100;
    endfunction

    // signed percent gap between measured and target rate
    function automatic longint rate_gap_pct(bit accumulate);
        longint r, tx, diff, coef;
        if (pkt_count < MIN_PKTS) return 0;
        r  = longint'({32'h0, rate_window});
        tx = longint'({32'h0, cfg_rate});
        if (r <= longint'({32'h0, rate_total >> 1})) r = longint'({32'h0, rate_total});
        diff = r - tx;
        coef = (diff / tx) * 100 + ((diff % tx) * 100) / tx;
        if (accumulate) begin
            coef += gap_accum;
            if (coef > 110 || coef < -90) gap_accum = 0;
            else gap_accum = clamp_s32(gap_accum + coef);
        end
        return coef;
    endfunction

    function automatic t_out_item pace_packet(t_in_item it);
        t_out_item   res;
        logic [31:0] wire_len, elapsed, t, span;
        logic [63:0] num;
        logic [31:0] hold;
        longint      three_q, ideal, dly, g, cur;
        longint      gap_val;
        wire_len = 32'(it.payload_bytes) + 32'(it.hdr_bytes) + LOW_HDR;
        hold     = '0;
        gap_val  = 0;
        if (cfg_rate != 0) begin
            elapsed = it.now_tick - last_tick;
            three_q = (longint'({32'h0, wire_len}) * 3) / 4;
            if (!(budget_ok && budget >= three_q)) begin
                ideal = 0;
                if (budget_ok) begin
                    dly = 1;
                end else begin
                    num   = 64'(TPS) * {32'h0, wire_len} + {32'h0, cfg_rate >> 1};
                    ideal = longint'(num / {32'h0, cfg_rate});
                    dly   = ideal - longint'({32'h0, elapsed});
                    if (dly > 0) begin
                        g       = rate_gap_pct(1'b1);
                        gap_val = clamp_s32(g);
                        dly    += percent_of(dly, g);
                    end
                end
                if (dly > 0) hold = (dly > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF : dly[31:0];
                // refill the byte budget when the budget falls short or the spacing rounds to zero
                if (ideal == 0) begin
                    g         = clamp_s32(rate_gap_pct(1'b0));
                    cur       = budget_ok ? budget : 0;
                    budget    = clamp_s32(longint'({32'h0, cfg_rate / TPS}) - percent_of(cur, g));
                    budget_ok = 1'b1;
                end else begin
                    budget_ok = 1'b0;
                end
            end
        end
        // book the packet as sent
        t = it.now_tick + hold;
        if (pkt_count != 32'hFFFFFFFF) pkt_count++;
        wire_total += {32'h0, wire_len};
        last_tick   = t;
        if (first_tick == 0) begin
            first_tick = t;
            win_tick   = t;
            win_bytes  = wire_total;
        end
        if (budget_ok) budget = clamp_s32(budget - longint'({32'h0, wire_len}));
        span = t - first_tick;
        if (first_tick != 0 && span != 0) rate_total = bytes_per_sec(wire_total, span);
        if (pkt_count >= {16'h0, cfg_window}) begin
            win_tick  = t - win_tick;
            win_bytes = wire_total - win_bytes;
            if (win_tick != 0 && win_bytes != 0) rate_window = bytes_per_sec(win_bytes, win_tick);
        end
        res.wait_ticks  = hold;
        res.rate_gap    = gap_val[31:0];
        res.overall_bps = rate_total;
        res.window_bps  = rate_window;
        return res;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= 30)
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     results_checked, field, want, got);
    endtask

    // accepted input items feed the predictor
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            pacing_expected.push_back(pace_packet(i_in));
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        out_fire <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pacing_expected.size() == 0) begin
                report("unexpected item wait_ticks", 32'h0, o_out.wait_ticks);
            end else begin
                want = pacing_expected.pop_front();
                if (o_out.wait_ticks !== want.wait_ticks)
                    report("wait_ticks", want.wait_ticks, o_out.wait_ticks);
                if (o_out.rate_gap !== want.rate_gap)
                    report("rate_gap", want.rate_gap, o_out.rate_gap);
                if (o_out.overall_bps !== want.overall_bps)
                    report("overall_bps", want.overall_bps, o_out.overall_bps);
                if (o_out.window_bps !== want.window_bps)
                    report("window_bps", want.window_bps, o_out.window_bps);
                if (want.wait_ticks != 0) waited_results++;
                if (want.rate_gap != 0) gapped_results++;
            end
            results_checked++;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            i_in_valid <= 1'b1;
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap--;
        end else if (packet_queue.size() != 0) begin
            i_in       <= packet_queue.pop_front();
            i_in_valid <= 1'b1;
            packets_offered++;
            send_gap = gap_burst ? 0 : $urandom_range(0, 10);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (out_fire) recv_stall = stall_burst ? 0 : $urandom_range(0, 10);
        if (recv_stall > 0) begin
            i_out_stall <= 1'b1;
            recv_stall--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        if (idx == REG_MAX_RATE) cfg_rate = val;
        else cfg_window = val[15:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        wait (packet_queue.size() == 0 && !i_in_valid && pacing_expected.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic offer(logic [15:0] pay, logic [7:0] hdr, logic [31:0] now);
        t_in_item it;
        it.payload_bytes = pay;
        it.hdr_bytes     = hdr;
        it.now_tick      = now;
        packet_queue.push_back(it);
    endtask

    // random traffic: mostly steadily advancing ticks with small packets
    task automatic offer_traffic(int count, inout logic [31:0] now);
        logic [15:0] pay;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0:       pay = 16'($urandom);
                1:       pay = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0;
                default: pay = 16'($urandom_range(0, 1500));
            endcase
            case ($urandom_range(0, 19))
                0:       now = $urandom;
                1:       now = now + $urandom_range(1000, 100000);
                default: now = now + $urandom_range(0, 40);
            endcase
            offer(pay, 8'($urandom), now);
            if (k % 40 == 0) begin
                gap_burst   = ($urandom_range(0, 3) == 0);
                stall_burst = ($urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        logic [31:0] now;
        logic [31:0] rates[9];
        logic [15:0] windows[9];
        errors          = 0;
        packets_offered = 0;
        results_checked = 0;
        waited_results  = 0;
        gapped_results  = 0;
        send_gap        = 0;
        recv_stall      = 0;
        gap_burst       = 1'b0;
        stall_burst     = 1'b0;
        in_fire         = 1'b0;
        out_fire        = 1'b0;
        i_in_valid      = 1'b0;
        i_in            = '0;
        i_out_stall     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_MAX_RATE;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        cfg_rate    = '0;
        cfg_window  = '0;
        pkt_count   = '0;
        wire_total  = '0;
        last_tick   = '0;
        first_tick  = '0;
        win_tick    = '0;
        win_bytes   = '0;
        budget      = 0;
        budget_ok   = 1'b1;
        rate_total  = '0;
        rate_window = '0;
        gap_accum   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unlimited rate: field extremes and tick wrap
        write_reg(REG_MAX_RATE, 32'h0);
        write_reg(REG_SAMPLE_LEN, 16'h0);
        offer(16'h0, 8'h0, 32'h0);
        offer(16'hFFFF, 8'hFF, 32'hFFFFFFFF);
        offer(16'h0, 8'hFF, 32'h00000001);
        offer(16'hFFFF, 8'h0, 32'h80000000);
        offer(16'h5555, 8'hAA, 32'hAAAAAAAA);
        drain();

        // slow target: budget hold, long spacing, stretch after enough samples
        write_reg(REG_MAX_RATE, 32'd1);
        write_reg(REG_SAMPLE_LEN, 16'hFFFF);
        now = 32'd100;
        for (int k = 0; k < 12; k++) begin
            offer(16'(k * 40), 8'(k), now);
            now = now + 32'd5;
        end
        offer(16'hFFFF, 8'hFF, now);
        offer(16'h0, 8'h0, 32'hFFFFFFF0);
        drain();

        // fastest target: spacing rounds to zero, budget refills
        write_reg(REG_MAX_RATE, 32'hFFFFFFFF);
        write_reg(REG_SAMPLE_LEN, 16'd1);
        now = 32'd5000;
        for (int k = 0; k < 6; k++) begin
            offer(16'hFFFF, 8'hFF, now);
            now = now + 32'd1;
        end
        drain();

        // random phases over a spread of targets and windows
        rates   = '{32'd2000, 32'd64000, 32'd1000000, 32'd500, 32'd12500000,
                    32'hFFFFFFFF, 32'd1, 32'h0, 32'd300000};
        windows = '{16'd10, 16'd0, 16'd50, 16'hFFFF, 16'd3, 16'd20, 16'd1, 16'd0, 16'd15};
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_MAX_RATE, ph % 3 == 2 ? $urandom_range(100, 2000000) : rates[ph]);
            write_reg(REG_SAMPLE_LEN, ph % 4 == 3 ? 16'($urandom_range(0, 40)) : windows[ph]);
            offer_traffic(200, now);
            drain();
        end

        $display("offered %0d packets over 12 target settings; %0d results checked, %0d held, %0d stretched",
                 packets_offered, results_checked, waited_results, gapped_results);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(64'd60_000_000);
        $display("timeout with %0d results outstanding", pacing_expected.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/tpr_pkg.sv
rtl/tpr_div.sv
rtl/tpr_mul.sv
rtl/transmit_rate_pacer.sv
tb/transmit_rate_pacer_tb.sv
